// File: design/thk_pkg.sv
// Package for the top-k heap core: status codes, opcodes, default depth.
// No dependencies.
package thk_pkg;
  localparam int HeapDepthDefault = 64;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_PUSH   = 2'd1,
    OP_POP    = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_REPLACED = 3'd2,
    ST_POPPED   = 3'd3,
    ST_FULL     = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_MODE     = 3'd6
  } status_e;

  localparam int EntryW = 80;  // score, key, handle
endpackage

// File: design/topk_heap_with_key_dedup_core.sv
// Top level of the bounded top-k heap with key dedup.
// Uses thk_pkg and thk_ram.
//
// One word is taken at a time. in_ready_o is high only while the sequencer is idle. Every
// cycle of work is one access to a single-port RAM, with one shared score comparator.
// Clear and the error cases go straight to the output. A push sifts up from the new last
// leaf. A pop fetches the root and the last entry, then sifts the last entry down from the
// root. An update first checks the root when the heap is full. It then scans the held keys
// and ends in a drop, a push or a sift-down as above. The worst case is an update to a
// full heap.
// The result sits in an output register. A new word can be accepted while it waits, but
// the next result is held back until the waiting one has been taken.
module topk_heap_with_key_dedup_core
  import thk_pkg::*;
#(
  parameter int HEAP_DEPTH = HeapDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] entry_score_i,
  input  logic [31:0] entry_key_i,
  input  logic [15:0] entry_handle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] out_score_o,
  output logic [31:0] out_key_o,
  output logic [15:0] out_handle_o,
  output logic [$clog2(HEAP_DEPTH+1)-1:0] fill_count_o
);
  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH+1);
  localparam logic [CW-1:0] Full = CW'(HEAP_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_ROOT_RD, S_ROOT_CHK, S_SCAN_RD, S_SCAN_CHK, S_POP_RD, S_POP_ROOT, S_POP_LAST,
    S_UP, S_UP_CHK, S_DN, S_DN_L, S_DN_R, S_DN_CHK, S_WR, S_OUT
  } state_e;

  state_e         state_q;
  logic           mode_q;
  logic [CW-1:0]  cnt_q;
  logic [EntryW-1:0] cur_q;     // entry being sifted
  logic [EntryW-1:0] lch_q;     // chosen child
  logic [CW-1:0]  midx_q;       // index of chosen child
  logic [CW-1:0]  idx_q;        // current node
  logic [CW-1:0]  scan_q;
  status_e        st_q;
  logic [EntryW-1:0] pop_q;
  logic           outv_q;
  logic [2:0]     res_st_q;
  logic [EntryW-1:0] res_ent_q;
  logic [CW-1:0]  res_fill_q;

  logic           we;
  logic [AW-1:0]  addr;
  logic [EntryW-1:0] wdata, rdata;

  thk_ram #(.Width(EntryW), .Depth(HEAP_DEPTH)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  function automatic logic prec(input logic m, input logic [31:0] a, input logic [31:0] b);
    prec = m ? ($signed(b) < $signed(a)) : ($signed(a) < $signed(b));
  endfunction

  logic [EntryW-1:0] in_e;
  assign in_e = {entry_score_i, entry_key_i, entry_handle_i};

  // child / parent index helpers
  logic [CW:0]   lidx, ridx;
  logic [CW-1:0] pidx, last_idx;
  assign lidx = {idx_q, 1'b1};
  assign ridx = {idx_q, 1'b0} + (CW+1)'(2);
  assign pidx = (idx_q - CW'(1)) >> 1;
  assign last_idx = cnt_q - CW'(1);

  // single shared comparator
  logic [31:0] ca, cb;
  logic cmp;
  assign cmp = prec(mode_q, ca, cb);

  always_comb begin
    ca = cur_q[79:48];
    cb = rdata[79:48];
    case (state_q)
      S_ROOT_CHK, S_SCAN_CHK, S_UP_CHK: begin
        ca = rdata[79:48];
        cb = cur_q[79:48];
      end
      S_DN_R: begin
        ca = lch_q[79:48];
        cb = rdata[79:48];
      end
      S_DN_CHK: cb = lch_q[79:48];
      default: ;
    endcase
  end

  always_comb begin
    we = 1'b0;
    addr = idx_q[AW-1:0];
    wdata = cur_q;
    case (state_q)
      S_ROOT_RD, S_POP_RD: addr = '0;
      S_POP_ROOT: addr = last_idx[AW-1:0];
      S_SCAN_RD: addr = scan_q[AW-1:0];
      S_UP: addr = pidx[AW-1:0];
      S_DN: addr = lidx[AW-1:0];
      S_DN_L: addr = ridx[AW-1:0];
      // a sift step moves the parent or the chosen child into the current node
      S_UP_CHK: if (!cmp) begin
        we = 1'b1;
        wdata = rdata;
      end
      S_DN_CHK: if (!cmp) begin
        we = 1'b1;
        wdata = lch_q;
      end
      S_WR: we = 1'b1;
      default: ;
    endcase
  end

  logic load_out;
  assign load_out = (state_q == S_OUT) && (!outv_q || out_ready_i);

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = outv_q;
  assign status_o     = res_st_q;
  assign out_score_o  = res_ent_q[79:48];
  assign out_key_o    = res_ent_q[47:16];
  assign out_handle_o = res_ent_q[15:0];
  assign fill_count_o = res_fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; mode_q <= 1'b0; cnt_q <= '0; outv_q <= 1'b0;
      cur_q <= '0; lch_q <= '0; midx_q <= '0; idx_q <= '0; scan_q <= '0;
      st_q <= ST_INSERTED; pop_q <= '0;
      res_st_q <= '0; res_ent_q <= '0; res_fill_q <= '0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (load_out) outv_q <= 1'b1;
      else if (out_ready_i) outv_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_valid_i) begin
          cur_q <= in_e; pop_q <= '0; scan_q <= '0;
          case (opcode_e'(opcode_i))
            OP_CLEAR: begin
              cnt_q <= '0; st_q <= ST_INSERTED; state_q <= S_OUT;
            end
            OP_PUSH: begin
              if (cnt_q == Full) begin
                st_q <= ST_FULL; state_q <= S_OUT;
              end else begin
                idx_q <= cnt_q; cnt_q <= cnt_q + CW'(1); st_q <= ST_INSERTED;
                state_q <= S_UP;
              end
            end
            OP_POP: begin
              if (cnt_q == '0) begin
                st_q <= ST_EMPTY; state_q <= S_OUT;
              end else begin
                st_q <= ST_POPPED; state_q <= S_POP_RD;
              end
            end
            OP_UPDATE: begin
              if (mode_q) begin
                st_q <= ST_MODE; state_q <= S_OUT;
              end else if (cnt_q == Full) begin
                state_q <= S_ROOT_RD;
              end else if (cnt_q == '0) begin
                idx_q <= cnt_q; cnt_q <= cnt_q + CW'(1); st_q <= ST_INSERTED;
                state_q <= S_UP;
              end else begin
                state_q <= S_SCAN_RD;
              end
            end
            default: ;
          endcase
        end
        S_ROOT_RD: state_q <= S_ROOT_CHK;
        // full heap: the new score must beat the root
        S_ROOT_CHK: begin
          if (!cmp) begin
            st_q <= ST_DROPPED; state_q <= S_OUT;
          end else begin
            state_q <= S_SCAN_RD;
          end
        end
        S_POP_RD: state_q <= S_POP_ROOT;
        S_POP_ROOT: begin
          pop_q <= rdata; state_q <= S_POP_LAST;
        end
        S_POP_LAST: begin
          cur_q <= rdata; cnt_q <= last_idx; idx_q <= '0; state_q <= S_DN;
        end
        S_SCAN_RD: state_q <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (rdata[47:16] == cur_q[47:16]) begin
            if (cmp) begin
              st_q <= ST_REPLACED; idx_q <= scan_q; state_q <= S_DN;
            end else begin
              st_q <= ST_DROPPED; state_q <= S_OUT;
            end
          end else if (scan_q + CW'(1) < cnt_q) begin
            scan_q <= scan_q + CW'(1); state_q <= S_SCAN_RD;
          end else if (cnt_q < Full) begin
            idx_q <= cnt_q; cnt_q <= cnt_q + CW'(1); st_q <= ST_INSERTED;
            state_q <= S_UP;
          end else begin
            st_q <= ST_REPLACED; idx_q <= '0; state_q <= S_DN;
          end
        end
        S_UP: state_q <= (idx_q == '0) ? S_WR : S_UP_CHK;
        S_UP_CHK: begin
          if (cmp) begin
            state_q <= S_WR;
          end else begin
            idx_q <= pidx; state_q <= S_UP;
          end
        end
        S_DN: state_q <= (lidx < {1'b0, cnt_q}) ? S_DN_L : S_WR;
        S_DN_L: begin
          lch_q <= rdata; midx_q <= lidx[CW-1:0];
          state_q <= (ridx < {1'b0, cnt_q}) ? S_DN_R : S_DN_CHK;
        end
        // right child wins unless the left strictly precedes it
        S_DN_R: begin
          if (!cmp) begin
            lch_q <= rdata; midx_q <= ridx[CW-1:0];
          end
          state_q <= S_DN_CHK;
        end
        S_DN_CHK: begin
          if (cmp) begin
            state_q <= S_WR;
          end else begin
            idx_q <= midx_q; state_q <= S_DN;
          end
        end
        S_WR: state_q <= S_OUT;
        S_OUT: if (load_out) begin
          res_st_q <= st_q; res_ent_q <= pop_q; res_fill_q <= cnt_q; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// File: design/thk_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module thk_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule
